[rtl/ugpb_pkg.sv]
`default_nettype none
package ugpb_pkg;

  // Fixed field widths
  localparam int ID_W      = 12;
  localparam int POS_W     = 24;
  localparam int SCALE_W   = 24;
  localparam int PROD_W    = 48;
  localparam int IDX_LSB   = 28;
  localparam int IDX_W     = PROD_W - IDX_LSB;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int REG_IDX_W = 3;
  localparam int ID_SPACE  = 4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_MIN_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_MUL,
    S_FRD,
    S_INS,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OUT_STATUS,
    OUT_PEND,
    OUT_FINAL
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic              clr_step;
    logic              latch_in;
    logic              cell_from_rec;
    logic              mul_en;
    logic              acc_en;
    logic [1:0]        axis;
    logic              fill_rd;
    logic              ins_commit;
    logic              del_commit;
    logic              scan_init;
    logic              scan_step;
    logic              out_load;
    out_sel_t          out_sel;
    logic [STAT_W-1:0] out_status;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic id_ok;
    logic found;
    logic fill_full;
    logic scan_end;
    logic scan_block;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/ugpb_ram.sv]
`default_nettype none
module ugpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/ugpb_ctrl.sv]
`default_nettype none
module ugpb_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [ugpb_pkg::CMD_W-1:0]   in_cmd,
  output logic                              in_ready,
  output ugpb_pkg::ctl_t                    ctl,
  input  wire ugpb_pkg::sts_t               sts
);

  ugpb_pkg::state_t              state_r, state_nxt;
  logic [ugpb_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [1:0]                    ax_r, ax_nxt;
  logic [ugpb_pkg::STAT_W-1:0]   status_r, status_nxt;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ugpb_pkg::S_CLEAR;
      cmd_r    <= ugpb_pkg::CMD_NONE;
      ax_r     <= 2'd0;
      status_r <= ugpb_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      cmd_r    <= cmd_nxt;
      ax_r     <= ax_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    ax_nxt     = ax_r;
    status_nxt = status_r;
    ctl        = '0;
    in_ready   = 1'b0;

    case (state_r)
      ugpb_pkg::S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ugpb_pkg::S_IDLE;
        end
      end

      ugpb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          cmd_nxt      = in_cmd;
          // drop the unused command without a result
          if (in_cmd != ugpb_pkg::CMD_NONE) begin
            state_nxt = ugpb_pkg::S_LOOK;
          end
        end
      end

      ugpb_pkg::S_LOOK: begin
        case (cmd_r)
          ugpb_pkg::CMD_INSERT: begin
            if (!sts.id_ok || sts.found) begin
              status_nxt = ugpb_pkg::ST_ABSENT;
              state_nxt  = ugpb_pkg::S_EMIT;
            end else begin
              ax_nxt    = 2'd0;
              state_nxt = ugpb_pkg::S_MUL;
            end
          end
          ugpb_pkg::CMD_DELETE: begin
            if (!sts.found) begin
              status_nxt = ugpb_pkg::ST_ABSENT;
            end else begin
              ctl.del_commit = 1'b1;
              status_nxt     = ugpb_pkg::ST_OK;
            end
            state_nxt = ugpb_pkg::S_EMIT;
          end
          ugpb_pkg::CMD_QUERY: begin
            if (!sts.found) begin
              status_nxt = ugpb_pkg::ST_ABSENT;
              state_nxt  = ugpb_pkg::S_EMIT;
            end else begin
              ctl.cell_from_rec = 1'b1;
              state_nxt         = ugpb_pkg::S_FRD;
            end
          end
          default: begin
            state_nxt = ugpb_pkg::S_IDLE;
          end
        endcase
      end

      // Three products through the shared multiplier, then the last accumulate
      ugpb_pkg::S_MUL: begin
        ctl.axis   = ax_r;
        ctl.mul_en = (ax_r != 2'd3);
        ctl.acc_en = (ax_r != 2'd0);
        ax_nxt     = ax_r + 2'd1;
        if (ax_r == 2'd3) begin
          state_nxt = ugpb_pkg::S_FRD;
        end
      end

      ugpb_pkg::S_FRD: begin
        ctl.fill_rd = 1'b1;
        if (cmd_r == ugpb_pkg::CMD_INSERT) begin
          state_nxt = ugpb_pkg::S_INS;
        end else begin
          ctl.scan_init = 1'b1;
          state_nxt     = ugpb_pkg::S_SCAN;
        end
      end

      ugpb_pkg::S_INS: begin
        if (sts.fill_full) begin
          status_nxt = ugpb_pkg::ST_FULL;
        end else begin
          ctl.ins_commit = 1'b1;
          status_nxt     = ugpb_pkg::ST_OK;
        end
        state_nxt = ugpb_pkg::S_EMIT;
      end

      // Walk the slots; hold while a held neighbor cannot be sent
      ugpb_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ugpb_pkg::S_FIN;
        end else if (!sts.scan_block || sts.out_free) begin
          ctl.scan_step = 1'b1;
          if (sts.scan_block) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = ugpb_pkg::OUT_PEND;
          end
        end
      end

      ugpb_pkg::S_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = ugpb_pkg::OUT_FINAL;
          state_nxt    = ugpb_pkg::S_IDLE;
        end
      end

      ugpb_pkg::S_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_sel    = ugpb_pkg::OUT_STATUS;
          ctl.out_status = status_r;
          state_nxt      = ugpb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ugpb_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/ugpb_dp.sv]
`default_nettype none
module ugpb_dp #(
  parameter int GRID_DIV      = 16,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_POINTS    = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ugpb_pkg::ctl_t                      ctl,
  output ugpb_pkg::sts_t                           sts,
  input  wire logic [ugpb_pkg::ID_W-1:0]           in_point_id,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_z,
  input  wire logic                                cfg_valid,
  input  wire logic [ugpb_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [ugpb_pkg::POS_W-1:0]          cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [ugpb_pkg::ID_W-1:0]                out_neighbor_id,
  output logic                                     out_has_neighbor,
  output logic                                     out_last,
  output logic [ugpb_pkg::STAT_W-1:0]              out_status
);

  localparam int NUM_CELLS = GRID_DIV * GRID_DIV * GRID_DIV;
  localparam int CW        = $clog2(NUM_CELLS);
  localparam int AXW       = $clog2(GRID_DIV);
  localparam int SW        = $clog2(CELL_CAPACITY);
  localparam int FW        = $clog2(CELL_CAPACITY + 1);
  localparam int REC_DEPTH = (MAX_POINTS < ugpb_pkg::ID_SPACE) ? MAX_POINTS : ugpb_pkg::ID_SPACE;
  localparam int RAW       = $clog2(REC_DEPTH);
  localparam int RECW      = CW + SW;
  localparam int SL_DEPTH  = NUM_CELLS * CELL_CAPACITY;
  localparam int SLAW      = $clog2(SL_DEPTH);
  localparam int SLW       = ugpb_pkg::ID_W + 1;
  localparam int CLR_DEPTH = (NUM_CELLS > REC_DEPTH) ? NUM_CELLS : REC_DEPTH;
  localparam int CLW       = $clog2(CLR_DEPTH);
  localparam int IDCW      = 17;

  localparam logic [CW-1:0]                 GDIV_C  = CW'(GRID_DIV);
  localparam logic [SLAW-1:0]               CAP_C   = SLAW'(CELL_CAPACITY);
  localparam logic [FW-1:0]                 CAPF_C  = FW'(CELL_CAPACITY);
  localparam logic [ugpb_pkg::IDX_W-1:0]    IDXMX_C = ugpb_pkg::IDX_W'(GRID_DIV - 1);
  localparam logic [AXW-1:0]                AXMX_C  = AXW'(GRID_DIV - 1);
  localparam logic [CLW-1:0]                CLRL_C  = CLW'(CLR_DEPTH - 1);
  localparam logic [IDCW-1:0]               MAXP_C  = IDCW'(MAX_POINTS);

  // Configuration registers
  logic signed [ugpb_pkg::POS_W-1:0]   min_x_r, min_y_r, min_z_r;
  logic [ugpb_pkg::SCALE_W-1:0]        scale_x_r, scale_y_r, scale_z_r;

  // Item registers
  logic [ugpb_pkg::ID_W-1:0]           id_r;
  logic                                id_ok_r;
  logic signed [ugpb_pkg::POS_W-1:0]   pos_x_r, pos_y_r, pos_z_r;
  logic [CW-1:0]                       cell_r, cell_nxt;
  logic [ugpb_pkg::PROD_W-1:0]         prod_r;
  logic                                prod_pos_r;

  // Scan registers
  logic [FW-1:0]                       scan_idx_r;
  logic                                chk_valid_r;
  logic                                pend_valid_r;
  logic [ugpb_pkg::ID_W-1:0]           pend_id_r;

  logic [CLW-1:0]                      clr_idx_r;

  // Output register
  logic                                out_valid_r;
  logic [ugpb_pkg::ID_W-1:0]           out_id_r;
  logic                                out_has_r;
  logic                                out_last_r;
  logic [ugpb_pkg::STAT_W-1:0]         out_status_r;

  // Memory ports
  logic                 fill_we;
  logic [CW-1:0]        fill_waddr;
  logic [FW-1:0]        fill_wdata, fill_rdata;
  logic                 pres_we, pres_wdata, pres_rdata;
  logic [RAW-1:0]       pres_waddr;
  logic [RECW-1:0]      rec_wdata, rec_rdata;
  logic                 slot_we, slot_re;
  logic [SLAW-1:0]      slot_waddr, slot_raddr;
  logic [SLW-1:0]       slot_wdata, slot_rdata;

  // Axis datapath signals
  logic signed [ugpb_pkg::POS_W-1:0]   pos_sel, min_sel;
  logic [ugpb_pkg::SCALE_W-1:0]        scale_sel;
  logic [ugpb_pkg::POS_W:0]            diff;
  logic                                diff_pos;
  logic [ugpb_pkg::PROD_W-1:0]         prod_nxt;
  logic [AXW-1:0]                      ax_idx;

  logic [CW-1:0]        rec_cell;
  logic [SW-1:0]        rec_slot;
  logic [SLAW-1:0]      ins_slot_addr, del_slot_addr;
  logic                 match;
  logic                 scan_more;
  logic                 out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      min_y_r   <= '0;
      min_z_r   <= '0;
      scale_x_r <= ugpb_pkg::SCALE_RESET;
      scale_y_r <= ugpb_pkg::SCALE_RESET;
      scale_z_r <= ugpb_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ugpb_pkg::REG_MIN_X:   min_x_r   <= cfg_data;
        ugpb_pkg::REG_MIN_Y:   min_y_r   <= cfg_data;
        ugpb_pkg::REG_MIN_Z:   min_z_r   <= cfg_data;
        ugpb_pkg::REG_SCALE_X: scale_x_r <= cfg_data;
        ugpb_pkg::REG_SCALE_Y: scale_y_r <= cfg_data;
        ugpb_pkg::REG_SCALE_Z: scale_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      id_r    <= in_point_id;
      id_ok_r <= (IDCW'(in_point_id) < MAXP_C);
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
    end
  end

  // Select the axis operands
  always_comb begin
    case (ctl.axis)
      2'd0: begin
        pos_sel   = pos_x_r;
        min_sel   = min_x_r;
        scale_sel = scale_x_r;
      end
      2'd1: begin
        pos_sel   = pos_y_r;
        min_sel   = min_y_r;
        scale_sel = scale_y_r;
      end
      default: begin
        pos_sel   = pos_z_r;
        min_sel   = min_z_r;
        scale_sel = scale_z_r;
      end
    endcase
  end

  // Offset from the corner, then the scaled product
  assign diff     = {pos_sel[ugpb_pkg::POS_W-1], pos_sel} - {min_sel[ugpb_pkg::POS_W-1], min_sel};
  assign diff_pos = !diff[ugpb_pkg::POS_W] && (diff != '0);
  assign prod_nxt = ugpb_pkg::PROD_W'(diff[ugpb_pkg::POS_W-1:0])
                  * ugpb_pkg::PROD_W'(scale_sel);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r     <= prod_nxt;
      prod_pos_r <= diff_pos;
    end
  end

  // Floor and saturate the registered product
  always_comb begin
    if (!prod_pos_r) begin
      ax_idx = '0;
    end else if (prod_r[ugpb_pkg::PROD_W-1:ugpb_pkg::IDX_LSB] > IDXMX_C) begin
      ax_idx = AXMX_C;
    end else begin
      ax_idx = prod_r[ugpb_pkg::IDX_LSB +: AXW];
    end
  end

  assign rec_cell = rec_rdata[RECW-1:SW];
  assign rec_slot = rec_rdata[SW-1:0];

  // Cell number: accumulate axes or take it from the point record
  always_comb begin
    cell_nxt = cell_r;
    if (ctl.latch_in) begin
      cell_nxt = '0;
    end else if (ctl.cell_from_rec) begin
      cell_nxt = rec_cell;
    end else if (ctl.acc_en) begin
      cell_nxt = CW'(cell_r * GDIV_C) + CW'(ax_idx);
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  // Clear sweep over fill counts and present flags after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (ctl.clr_step) begin
      clr_idx_r <= clr_idx_r + CLW'(1);
    end
  end

  // Fill count store
  always_comb begin
    if (ctl.clr_step) begin
      fill_we    = (32'(clr_idx_r) < NUM_CELLS);
      fill_waddr = clr_idx_r[CW-1:0];
      fill_wdata = '0;
    end else begin
      fill_we    = ctl.ins_commit;
      fill_waddr = cell_r;
      fill_wdata = fill_rdata + FW'(1);
    end
  end

  ugpb_ram #(.WIDTH(FW), .DEPTH(NUM_CELLS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (ctl.fill_rd),
    .raddr (cell_r),
    .rdata (fill_rdata)
  );

  // Present flag store
  always_comb begin
    if (ctl.clr_step) begin
      pres_we    = (32'(clr_idx_r) < REC_DEPTH);
      pres_waddr = clr_idx_r[RAW-1:0];
      pres_wdata = 1'b0;
    end else begin
      pres_we    = ctl.ins_commit || ctl.del_commit;
      pres_waddr = id_r[RAW-1:0];
      pres_wdata = ctl.ins_commit;
    end
  end

  ugpb_ram #(.WIDTH(1), .DEPTH(REC_DEPTH)) u_pres_ram (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wdata),
    .re    (ctl.latch_in),
    .raddr (in_point_id[RAW-1:0]),
    .rdata (pres_rdata)
  );

  // Point record store: cell and slot per id
  assign rec_wdata = {cell_r, fill_rdata[SW-1:0]};

  ugpb_ram #(.WIDTH(RECW), .DEPTH(REC_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (ctl.ins_commit),
    .waddr (id_r[RAW-1:0]),
    .wdata (rec_wdata),
    .re    (ctl.latch_in),
    .raddr (in_point_id[RAW-1:0]),
    .rdata (rec_rdata)
  );

  // Slot store addressing
  assign ins_slot_addr = SLAW'(cell_r) * CAP_C + SLAW'(fill_rdata[SW-1:0]);
  assign del_slot_addr = SLAW'(rec_cell) * CAP_C + SLAW'(rec_slot);
  assign slot_raddr    = SLAW'(cell_r) * CAP_C + SLAW'(scan_idx_r[SW-1:0]);

  always_comb begin
    slot_we    = ctl.ins_commit || ctl.del_commit;
    slot_waddr = ctl.ins_commit ? ins_slot_addr : del_slot_addr;
    slot_wdata = ctl.ins_commit ? {1'b1, id_r} : '0;
  end

  assign scan_more = (scan_idx_r < fill_rdata);
  assign slot_re   = ctl.scan_step && scan_more;

  ugpb_ram #(.WIDTH(SLW), .DEPTH(SL_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Live slot other than the queried id
  assign match = chk_valid_r && slot_rdata[ugpb_pkg::ID_W]
              && (slot_rdata[ugpb_pkg::ID_W-1:0] != id_r);

  // Scan counter and one held neighbor, so the last one can carry the mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      chk_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (ctl.scan_init) begin
      scan_idx_r   <= '0;
      chk_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (ctl.scan_step) begin
      if (match) begin
        pend_valid_r <= 1'b1;
      end
      chk_valid_r <= scan_more;
      if (scan_more) begin
        scan_idx_r <= scan_idx_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_step && match) begin
      pend_id_r <= slot_rdata[ugpb_pkg::ID_W-1:0];
    end
  end

  // Output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.out_sel)
        ugpb_pkg::OUT_PEND: begin
          out_id_r     <= pend_id_r;
          out_has_r    <= 1'b1;
          out_last_r   <= 1'b0;
          out_status_r <= ugpb_pkg::ST_OK;
        end
        ugpb_pkg::OUT_FINAL: begin
          out_id_r     <= pend_valid_r ? pend_id_r : '0;
          out_has_r    <= pend_valid_r;
          out_last_r   <= 1'b1;
          out_status_r <= ugpb_pkg::ST_OK;
        end
        default: begin
          out_id_r     <= '0;
          out_has_r    <= 1'b0;
          out_last_r   <= 1'b1;
          out_status_r <= ctl.out_status;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neighbor_id  = out_id_r;
  assign out_has_neighbor = out_has_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_idx_r == CLRL_C);
    sts.id_ok      = id_ok_r;
    sts.found      = id_ok_r && pres_rdata;
    sts.fill_full  = (fill_rdata >= CAPF_C);
    sts.scan_end   = !scan_more && !chk_valid_r;
    sts.scan_block = match && pend_valid_r;
    sts.out_free   = out_free;
  end

endmodule
`default_nettype wire

[rtl/uniform_grid_point_bins_unit.sv]
`default_nettype none
// Uniform grid point bins.
// Input beats (in_valid/in_ready) carry a command, a point id and a Q12.12
// position. Insert bins the point into a GRID_DIV^3 grid and appends it to its
// cell; delete kills the point's slot; query lists the other live points of
// the point's cell. Insert and delete give one result beat; a query gives one
// beat per neighbor (or one empty beat), with out_last on the final one.
// Command 3 is taken and dropped with no result.
// The cfg channel writes the grid corner and per-axis scales; cfg_ready is
// always high. Write it only while the block is idle.
// One item is handled at a time. Insert runs three axis products through one
// 24x24 multiplier, then a fill-count read and write; a query walks the used
// slots of the cell, since the slot memory is read one entry per cycle, unless
// a neighbor waits on a stalled receiver.
// After reset the block clears the fill counts and present flags, one entry
// per cycle over max(GRID_DIV^3, min(MAX_POINTS, 4096)) entries (4096 with
// default parameters); in_ready stays low until that sweep ends.
// A stalled receiver holds the result register, and the scan stops at the
// next neighbor to send until the beat is taken.
module uniform_grid_point_bins_unit #(
  parameter int GRID_DIV      = 16,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_POINTS    = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [ugpb_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [ugpb_pkg::ID_W-1:0]           in_point_id,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]   in_pos_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ugpb_pkg::ID_W-1:0]                out_neighbor_id,
  output logic                                     out_has_neighbor,
  output logic                                     out_last,
  output logic [ugpb_pkg::STAT_W-1:0]              out_status,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ugpb_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [ugpb_pkg::POS_W-1:0]          cfg_data
);

  ugpb_pkg::ctl_t ctl;
  ugpb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ugpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  ugpb_dp #(
    .GRID_DIV      (GRID_DIV),
    .CELL_CAPACITY (CELL_CAPACITY),
    .MAX_POINTS    (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_point_id      (in_point_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_neighbor_id  (out_neighbor_id),
    .out_has_neighbor (out_has_neighbor),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

[bench/grid_bins_checker.sv]
`default_nettype none
module grid_bins_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [ugpb_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [ugpb_pkg::ID_W-1:0]          in_point_id,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [ugpb_pkg::POS_W-1:0]  in_pos_z,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [ugpb_pkg::ID_W-1:0]          out_neighbor_id,
  input  wire logic                               out_has_neighbor,
  input  wire logic                               out_last,
  input  wire logic [ugpb_pkg::STAT_W-1:0]        out_status,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [ugpb_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [ugpb_pkg::POS_W-1:0]         cfg_data,
  output int                                      error_count,
  output int                                      answers_pending
);

  localparam int GRID_DIV = 16;
  localparam int CELL_CAP = 16;
  localparam int NUM_BINS = GRID_DIV * GRID_DIV * GRID_DIV;

  typedef struct packed {
    logic [ugpb_pkg::ID_W-1:0]   neighbor;
    logic                        occupied;
    logic                        final_beat;
    logic [ugpb_pkg::STAT_W-1:0] status;
  } bin_answer_t;

  // Result beats still owed by the unit, oldest first
  bin_answer_t grid_answers[$];

  // Shadow grid: fill per bin, live bit plus id per slot, home of each id
  logic [4:0]                        fill_count [NUM_BINS];
  logic [ugpb_pkg::ID_W:0]           slot_mem   [NUM_BINS][CELL_CAP];
  logic [11:0]                       home_bin   [ugpb_pkg::ID_SPACE];
  logic [3:0]                        home_slot  [ugpb_pkg::ID_SPACE];
  logic                              id_live    [ugpb_pkg::ID_SPACE];
  logic signed [ugpb_pkg::POS_W-1:0] corner   [3];
  logic [ugpb_pkg::SCALE_W-1:0]      per_unit [3];

  // Bin index on one axis: floor of the Q20.28 product, clamped to the grid
  function automatic logic [3:0] axis_bin(input logic signed [ugpb_pkg::POS_W-1:0] pos,
                                          input logic signed [ugpb_pkg::POS_W-1:0] lo,
                                          input logic [ugpb_pkg::SCALE_W-1:0] scale);
    logic signed [ugpb_pkg::POS_W:0] diff;
    logic [ugpb_pkg::PROD_W-1:0]     prod;
    logic [ugpb_pkg::IDX_W-1:0]      whole;
    diff = {pos[ugpb_pkg::POS_W-1], pos} - {lo[ugpb_pkg::POS_W-1], lo};
    if (diff <= 0) return 4'd0;
    prod = diff[ugpb_pkg::POS_W-1:0] * scale;
    whole = prod[ugpb_pkg::PROD_W-1:ugpb_pkg::IDX_LSB];
    if (whole > GRID_DIV - 1) return 4'(GRID_DIV - 1);
    return whole[3:0];
  endfunction

  function automatic bin_answer_t make_answer(input logic [ugpb_pkg::ID_W-1:0] nid,
                                              input logic occ, input logic fin,
                                              input logic [ugpb_pkg::STAT_W-1:0] st);
    bin_answer_t a;
    a.neighbor   = nid;
    a.occupied   = occ;
    a.final_beat = fin;
    a.status     = st;
    return a;
  endfunction

  task automatic report_mismatch(input string what, input bin_answer_t got,
                                 input bin_answer_t want);
    $display("grid check @%0t: %s: got %0d/%0b/%0b/%0d, want %0d/%0b/%0b/%0d",
             $time, what, got.neighbor, got.occupied, got.final_beat, got.status,
             want.neighbor, want.occupied, want.final_beat, want.status);
    error_count++;
  endtask

  // Update the shadow grid for one command and queue the beats it owes
  task automatic apply_grid_command(input logic [ugpb_pkg::CMD_W-1:0] cmd,
                                    input logic [ugpb_pkg::ID_W-1:0] id,
                                    input logic signed [ugpb_pkg::POS_W-1:0] px,
                                    input logic signed [ugpb_pkg::POS_W-1:0] py,
                                    input logic signed [ugpb_pkg::POS_W-1:0] pz);
    logic [11:0]             bin_no;
    logic [4:0]              used;
    logic [ugpb_pkg::ID_W:0] entry;
    bin_answer_t             held;
    logic                    have_held;
    int                      s;
    case (cmd)
      ugpb_pkg::CMD_INSERT: begin
        if (id_live[id]) begin
          grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_ABSENT));
        end else begin
          bin_no = {axis_bin(px, corner[0], per_unit[0]),
                    axis_bin(py, corner[1], per_unit[1]),
                    axis_bin(pz, corner[2], per_unit[2])};
          used = fill_count[bin_no];
          if (used >= CELL_CAP) begin
            grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_FULL));
          end else begin
            slot_mem[bin_no][used[3:0]] = {1'b1, id};
            home_bin[id]   = bin_no;
            home_slot[id]  = used[3:0];
            id_live[id]    = 1'b1;
            fill_count[bin_no] = used + 5'd1;
            grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_OK));
          end
        end
      end
      ugpb_pkg::CMD_DELETE: begin
        if (!id_live[id]) begin
          grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_ABSENT));
        end else begin
          // Kill the slot; it is never handed out again
          slot_mem[home_bin[id]][home_slot[id]] = '0;
          id_live[id] = 1'b0;
          grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_OK));
        end
      end
      ugpb_pkg::CMD_QUERY: begin
        if (!id_live[id]) begin
          grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_ABSENT));
        end else begin
          bin_no = home_bin[id];
          used = fill_count[bin_no];
          have_held = 1'b0;
          held = '0;
          // Hold back each neighbor one step so the final one gets the last mark
          for (s = 0; s < CELL_CAP; s++) begin
            if (s < used) begin
              entry = slot_mem[bin_no][s];
              if (entry[ugpb_pkg::ID_W] && entry[ugpb_pkg::ID_W-1:0] != id) begin
                if (have_held) grid_answers.push_back(held);
                held = make_answer(entry[ugpb_pkg::ID_W-1:0], 1'b1, 1'b0, ugpb_pkg::ST_OK);
                have_held = 1'b1;
              end
            end
          end
          if (have_held) begin
            held.final_beat = 1'b1;
            grid_answers.push_back(held);
          end else begin
            grid_answers.push_back(make_answer('0, 1'b0, 1'b1, ugpb_pkg::ST_OK));
          end
        end
      end
      default: begin
        // Unused command: taken and dropped, nothing owed
      end
    endcase
  endtask

  always @(posedge clk) begin
    bin_answer_t got;
    bin_answer_t want;
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) fill_count[b] = '0;
      for (int i = 0; i < ugpb_pkg::ID_SPACE; i++) id_live[i] = 1'b0;
      for (int a = 0; a < 3; a++) begin
        corner[a]   = '0;
        per_unit[a] = ugpb_pkg::SCALE_RESET;
      end
      grid_answers.delete();
      error_count = 0;
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ugpb_pkg::REG_MIN_X:   corner[0]   = cfg_data;
          ugpb_pkg::REG_MIN_Y:   corner[1]   = cfg_data;
          ugpb_pkg::REG_MIN_Z:   corner[2]   = cfg_data;
          ugpb_pkg::REG_SCALE_X: per_unit[0] = cfg_data;
          ugpb_pkg::REG_SCALE_Y: per_unit[1] = cfg_data;
          ugpb_pkg::REG_SCALE_Z: per_unit[2] = cfg_data;
          default: ;
        endcase
      end
      // Command beats
      if (in_valid && in_ready)
        apply_grid_command(in_cmd, in_point_id, in_pos_x, in_pos_y, in_pos_z);
      // Result beats
      if (out_valid && out_ready) begin
        got = make_answer(out_neighbor_id, out_has_neighbor, out_last, out_status);
        if (grid_answers.size() == 0) begin
          report_mismatch("result beat with nothing owed", got, '0);
        end else begin
          want = grid_answers.pop_front();
          if (got.neighbor !== want.neighbor || got.occupied !== want.occupied ||
              got.final_beat !== want.final_beat || got.status !== want.status)
            report_mismatch("result beat differs", got, want);
        end
      end
    end
    answers_pending = grid_answers.size();
  end

endmodule
`default_nettype wire

[bench/uniform_grid_point_bins_unit_tb.sv]
`default_nettype none
module uniform_grid_point_bins_unit_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [ugpb_pkg::CMD_W-1:0]        in_cmd;
  logic [ugpb_pkg::ID_W-1:0]         in_point_id;
  logic signed [ugpb_pkg::POS_W-1:0] in_pos_x;
  logic signed [ugpb_pkg::POS_W-1:0] in_pos_y;
  logic signed [ugpb_pkg::POS_W-1:0] in_pos_z;
  logic                              out_valid;
  logic                              out_ready;
  logic [ugpb_pkg::ID_W-1:0]         out_neighbor_id;
  logic                              out_has_neighbor;
  logic                              out_last;
  logic [ugpb_pkg::STAT_W-1:0]       out_status;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [ugpb_pkg::REG_IDX_W-1:0]    cfg_index;
  logic [ugpb_pkg::POS_W-1:0]        cfg_data;

  int check_errors;
  int answers_open;

  // Stimulus shaping state
  logic                              calm;
  int                                next_gap;
  int                                item_no;
  int                                beats_taken;
  int                                idle_cycles;
  logic signed [ugpb_pkg::POS_W-1:0] grid_lo    [3];
  logic [ugpb_pkg::SCALE_W-1:0]      grid_scale [3];
  int                                bins_pick  [4][3];
  logic [ugpb_pkg::ID_W-1:0]         seen_ids[$];

  uniform_grid_point_bins_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_point_id      (in_point_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_neighbor_id  (out_neighbor_id),
    .out_has_neighbor (out_has_neighbor),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  grid_bins_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_point_id      (in_point_id),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_neighbor_id  (out_neighbor_id),
    .out_has_neighbor (out_has_neighbor),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .error_count      (check_errors),
    .answers_pending  (answers_open)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [ugpb_pkg::POS_W-1:0] any_pos();
    return ugpb_pkg::POS_W'($urandom());
  endfunction

  // Position that lands near the middle of bin k on axis a under the current grid
  function automatic logic signed [ugpb_pkg::POS_W-1:0] pos_in_bin(input int k, input int a);
    longint span;
    longint p;
    if (grid_scale[a] == 0) return any_pos();
    span = (longint'(1) << 28) / longint'(grid_scale[a]);
    p = longint'(grid_lo[a]) + k * span + span / 4
        + longint'($urandom_range(0, 32'(span / 2)));
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[ugpb_pkg::POS_W-1:0];
  endfunction

  // Offer one command beat; hold it until taken, then draw the next gap
  task automatic send_item(input logic [ugpb_pkg::CMD_W-1:0] cmd,
                           input logic [ugpb_pkg::ID_W-1:0] id,
                           input logic signed [ugpb_pkg::POS_W-1:0] px,
                           input logic signed [ugpb_pkg::POS_W-1:0] py,
                           input logic signed [ugpb_pkg::POS_W-1:0] pz);
    if (next_gap > 0) repeat (next_gap) @(negedge clk);
    in_cmd      = cmd;
    in_point_id = id;
    in_pos_x    = px;
    in_pos_y    = py;
    in_pos_z    = pz;
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    next_gap = calm ? 0 : $urandom_range(0, 6);
    if (next_gap > 0) in_valid = 1'b0;
  endtask

  // Drop valid and let the unit drain before touching the registers
  task automatic wait_idle();
    in_valid = 1'b0;
    while (answers_open != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ugpb_pkg::REG_IDX_W-1:0] idx,
                           input logic [ugpb_pkg::POS_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [ugpb_pkg::POS_W-1:0] mx,
                          input logic [ugpb_pkg::POS_W-1:0] my,
                          input logic [ugpb_pkg::POS_W-1:0] mz,
                          input logic [ugpb_pkg::SCALE_W-1:0] sx,
                          input logic [ugpb_pkg::SCALE_W-1:0] sy,
                          input logic [ugpb_pkg::SCALE_W-1:0] sz);
    write_reg(ugpb_pkg::REG_MIN_X, mx);
    write_reg(ugpb_pkg::REG_MIN_Y, my);
    write_reg(ugpb_pkg::REG_MIN_Z, mz);
    write_reg(ugpb_pkg::REG_SCALE_X, sx);
    write_reg(ugpb_pkg::REG_SCALE_Y, sy);
    write_reg(ugpb_pkg::REG_SCALE_Z, sz);
    cfg_valid = 1'b0;
    grid_lo[0] = mx;
    grid_lo[1] = my;
    grid_lo[2] = mz;
    grid_scale[0] = sx;
    grid_scale[1] = sy;
    grid_scale[2] = sz;
  endtask

  // Reset grid: one unit per bin, corner at the origin
  task automatic run_directed();
    int k;
    send_item(ugpb_pkg::CMD_QUERY, 12'd5, any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_DELETE, 12'd5, any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_INSERT, 12'd0, 24'sd0, 24'sd0, 24'sd0);
    // Id already present
    send_item(ugpb_pkg::CMD_INSERT, 12'd0, 24'sh001800, 24'sd0, 24'sd0);
    // Alone in its bin: empty answer
    send_item(ugpb_pkg::CMD_QUERY, 12'd0, any_pos(), any_pos(), any_pos());
    // Below the corner on every axis
    send_item(ugpb_pkg::CMD_INSERT, 12'hFFF, 24'sh800000, 24'shFFFFFF, 24'shFFF000);
    // Beyond the upper edge on every axis
    send_item(ugpb_pkg::CMD_INSERT, 12'hAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(ugpb_pkg::CMD_INSERT, 12'h555, 24'sh005800, 24'sh001000, 24'sh000FFF);
    send_item(ugpb_pkg::CMD_QUERY, 12'hFFF, any_pos(), any_pos(), any_pos());
    // Fill bin zero up to capacity
    for (k = 1; k <= 14; k++)
      send_item(ugpb_pkg::CMD_INSERT, ugpb_pkg::ID_W'(k * 273 + 1),
                ugpb_pkg::POS_W'(k * 37), ugpb_pkg::POS_W'(k * 101),
                ugpb_pkg::POS_W'(k * 211));
    // Bin full
    send_item(ugpb_pkg::CMD_INSERT, 12'h800, 24'sh000100, 24'sh000200, 24'sh000300);
    send_item(ugpb_pkg::CMD_DELETE, ugpb_pkg::ID_W'(3 * 273 + 1),
              any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_QUERY, ugpb_pkg::ID_W'(3 * 273 + 1),
              any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_QUERY, 12'd0, any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_DELETE, 12'hAAA, any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_QUERY, 12'h555, any_pos(), any_pos(), any_pos());
    send_item(ugpb_pkg::CMD_NONE, ugpb_pkg::ID_W'($urandom()),
              any_pos(), any_pos(), any_pos());
  endtask

  // Mostly well-formed traffic on a few crowded bins, plus noise
  task automatic random_item();
    int r;
    int pick;
    int which;
    int a;
    logic [ugpb_pkg::ID_W-1:0] id;
    logic signed [ugpb_pkg::POS_W-1:0] p [3];
    calm = ((item_no / 25) % 4) == 3;
    item_no++;
    r = $urandom_range(0, 99);
    for (a = 0; a < 3; a++) p[a] = any_pos();
    id = ugpb_pkg::ID_W'($urandom_range(0, ugpb_pkg::ID_SPACE - 1));
    if (r < 40) begin
      if (seen_ids.size() > 0 && $urandom_range(0, 9) == 0)
        id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
      else
        seen_ids.push_back(id);
      if ($urandom_range(0, 6) != 0) begin
        which = $urandom_range(0, 3);
        for (a = 0; a < 3; a++) p[a] = pos_in_bin(bins_pick[which][a], a);
      end
      send_item(ugpb_pkg::CMD_INSERT, id, p[0], p[1], p[2]);
    end else if (r < 55) begin
      if (seen_ids.size() > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, seen_ids.size() - 1);
        id = seen_ids[pick];
        seen_ids.delete(pick);
      end
      send_item(ugpb_pkg::CMD_DELETE, id, p[0], p[1], p[2]);
    end else if (r < 93) begin
      if (seen_ids.size() > 0 && $urandom_range(0, 9) != 0)
        id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
      send_item(ugpb_pkg::CMD_QUERY, id, p[0], p[1], p[2]);
    end else begin
      send_item(ugpb_pkg::CMD_NONE, id, p[0], p[1], p[2]);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int ph;
    int n;
    int count;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = ugpb_pkg::CMD_INSERT;
    in_point_id = '0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_pos_z    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = ugpb_pkg::REG_MIN_X;
    cfg_data    = '0;
    calm        = 1'b0;
    next_gap    = 0;
    item_no     = 0;
    for (int a = 0; a < 3; a++) begin
      grid_lo[a]    = '0;
      grid_scale[a] = ugpb_pkg::SCALE_RESET;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (ph = 1; ph <= 4; ph++) begin
      wait_idle();
      case (ph)
        1: begin
          set_grid(24'hFF8000, 24'h004000, 24'hFFE000,
                   24'h010000, 24'h010000, 24'h010000);
          count = 90;
        end
        2: begin
          set_grid(24'h123456, 24'hCBA988, 24'h000000,
                   24'h008000, 24'h020000, 24'h004000);
          count = 80;
        end
        3: begin
          // Extremes: lowest and highest corner, widest scale, zero scale
          set_grid(24'h800000, 24'h7FFFFF, 24'h000000,
                   24'hFFFFFF, 24'h000000, 24'h000001);
          count = 40;
        end
        default: begin
          set_grid(24'h000000, 24'h000000, 24'h000000, ugpb_pkg::SCALE_RESET,
                   ugpb_pkg::SCALE_RESET, ugpb_pkg::SCALE_RESET);
          count = 40;
        end
      endcase
      for (int b = 0; b < 4; b++)
        for (int a = 0; a < 3; a++) bins_pick[b][a] = $urandom_range(0, 15);
      for (n = 0; n < count; n++) random_item();
    end

    wait_idle();
    repeat (60) @(negedge clk);
    if (check_errors == 0) begin
      $display("uniform_grid_point_bins_unit_tb: done, clean");
    end else begin
      $display("uniform_grid_point_bins_unit_tb: done, errors");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and two long hold-offs
  initial begin
    int hold;
    out_ready   = 1'b0;
    beats_taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (beats_taken == 60 || beats_taken == 220)
        hold = LONG_HOLD;
      else
        hold = calm ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("uniform_grid_point_bins_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

[uniform_grid_point_bins_unit.f]
rtl/ugpb_pkg.sv
rtl/ugpb_ram.sv
rtl/ugpb_ctrl.sv
rtl/ugpb_dp.sv
rtl/uniform_grid_point_bins_unit.sv
bench/grid_bins_checker.sv
bench/uniform_grid_point_bins_unit_tb.sv
